// ----- hdl/ardf_pkg.sv -----
// shared types and constants for the reply frame deframer
`timescale 1ns / 1ps

package ardf_pkg;

   localparam logic [15:0] SYNC_RESET   = 16'hAFAF;
   localparam logic [7:0]  HEADER_BYTES = 8'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT     = 3'd0,
      PH_HEADER   = 3'd1,
      PH_COMMAND  = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_PAYLOAD  = 3'd4,
      PH_CHECKSUM = 3'd5,
      PH_END_LOW  = 3'd6,
      PH_END_HIGH = 3'd7
   } phase_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  position;
      logic [7:0]  command;
      logic [7:0]  length;
      logic        checksum_ok;
      logic [15:0] end_word;
      logic        last;
   } result_type;

endpackage

// ----- hdl/ardf_core.sv -----
// frame state machine: sync hunt, header walk, running sum and result build
`timescale 1ns / 1ps

module ardf_core
   import ardf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  in_byte,
   input  logic [15:0] sync_word,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  sum_rx_ff, sum_rx_in;
   logic [7:0]  end_low_ff, end_low_in;

   logic [8:0]  count_inc;
   logic        sync_hit;

   assign count_inc = {1'b0, count_ff} + 9'd1;
   assign sync_hit  = prev_valid_ff && ({in_byte, prev_byte_ff} == sync_word);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      prev_byte_in  = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      command_in    = command_ff;
      length_in     = length_ff;
      sum_rx_in     = sum_rx_ff;
      end_low_in    = end_low_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (sync_hit) begin
               sum_in   = prev_byte_ff + in_byte;
               count_in = '0;
               phase_in = PH_HEADER;
            end else begin
               prev_byte_in  = in_byte;
               prev_valid_in = 1'b1;
            end
         end
         PH_HEADER: begin
            sum_in   = sum_ff + in_byte;
            count_in = count_inc[7:0];
            if (count_inc >= {1'b0, HEADER_BYTES}) begin
               count_in = '0;
               phase_in = PH_COMMAND;
            end
         end
         PH_COMMAND: begin
            sum_in     = sum_ff + in_byte;
            command_in = in_byte;
            phase_in   = PH_LENGTH;
         end
         PH_LENGTH: begin
            sum_in    = sum_ff + in_byte;
            length_in = in_byte;
            count_in  = '0;
            phase_in  = (in_byte == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_in   = sum_ff + in_byte;
            count_in = count_inc[7:0];
            if (count_inc >= {1'b0, length_ff}) phase_in = PH_CHECKSUM;
         end
         PH_CHECKSUM: begin
            sum_rx_in = in_byte;
            phase_in  = PH_END_LOW;
         end
         PH_END_LOW: begin
            end_low_in = in_byte;
            phase_in   = PH_END_HIGH;
         end
         PH_END_HIGH: begin
            phase_in      = PH_HUNT;
            prev_valid_in = 1'b0;
            prev_byte_in  = '0;
            count_in      = '0;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // result for the byte being stepped
   always_comb begin
      result = '0;
      result.command = command_ff;
      result.length  = length_ff;
      unique case (phase_ff)
         PH_PAYLOAD: begin
            result.valid     = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data_byte = in_byte;
            result.position  = count_ff;
         end
         PH_END_HIGH: begin
            result.valid       = 1'b1;
            result.kind        = KIND_VERDICT;
            result.checksum_ok = (sum_rx_ff == sum_ff);
            result.end_word    = {in_byte, end_low_ff};
            result.last        = 1'b1;
         end
         default: result.valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         prev_byte_ff  <= '0;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         command_ff    <= '0;
         length_ff     <= '0;
         sum_rx_ff     <= '0;
         end_low_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         prev_byte_ff  <= prev_byte_in;
         prev_valid_ff <= prev_valid_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         command_ff    <= command_in;
         length_ff     <= length_in;
         sum_rx_ff     <= sum_rx_in;
         end_low_ff    <= end_low_in;
      end
   end

`ifndef SYNTHESIS
   a_verdict_rehunts: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_END_HIGH |=> phase_ff == PH_HUNT && !prev_valid_ff)
      else $error("verdict did not restart the hunt");
   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < length_ff)
      else $error("payload offset ran past the length");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(sum_ff))
      else $error("state moved without a byte");
`endif

endmodule

// ----- hdl/at_reply_frame_deframer.sv -----
// top level of the reply frame deframer: input register, core, result register
`timescale 1ns / 1ps
// Reply frame deframer. Bytes of the serial stream come in on the req_ channel
// (req_valid / req_stall, one byte per beat). Payload bytes and the closing
// frame verdict leave on the rsp_ channel (rsp_valid / rsp_stall), one result
// per beat. The sync word is written through csr_valid / csr_ready with
// csr_sync_word; csr_ready is always high, write only while the block is idle.
// A byte accepted on req_ passes through the input register and the core into
// the result register, and its result, if any, leaves there as a valid rsp_
// beat. Throughput is one byte per cycle while the receiver does not hold
// rsp_stall; the frame state machine updates its state on each stepped byte.
// When the receiver holds rsp_stall with a result waiting, the byte in the
// input register waits and req_stall rises; nothing is dropped.
// Synchronous reset returns the sync word to 0xAFAF, empties both registers and
// puts the deframer back into the sync hunt with no previous byte.
module at_reply_frame_deframer
   import ardf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_position,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_length,
   output logic        rsp_checksum_ok,
   output logic [15:0] rsp_end_word,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_sync_word
);

   logic [15:0] sync_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   result_type  out_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  core_result;
   logic        out_free, step, req_beat;

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) out_valid_in = step && core_result.valid;
   end

   ardf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .sync_word (sync_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) sync_ff <= csr_sync_word;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) in_byte_ff <= req_in_byte;
      if (out_free) out_ff <= core_result;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_position    = out_ff.position;
   assign rsp_command     = out_ff.command;
   assign rsp_length      = out_ff.length;
   assign rsp_checksum_ok = out_ff.checksum_ok;
   assign rsp_end_word    = out_ff.end_word;
   assign rsp_last        = out_ff.last;

`ifndef SYNTHESIS
   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with nothing waiting");
   a_last_is_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == KIND_VERDICT)))
      else $error("last flag does not match result kind");
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |-> !rsp_checksum_ok && rsp_end_word == 16'd0)
      else $error("payload beat carries verdict fields");
   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VERDICT |-> rsp_data_byte == 8'd0 && rsp_position == 8'd0)
      else $error("verdict beat carries payload fields");
`endif

endmodule

// ----- sim/tb_at_reply_frame_deframer.sv -----
// testbench for the reply frame deframer: framed byte streams checked against a local predictor
`timescale 1ns / 1ps

module tb_at_reply_frame_deframer;
   import ardf_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   localparam int TARGET_BYTES = 1850;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 10;
   localparam int HOLDOFF_LEN  = 150;
   localparam int RESYNC_EVERY = 300;

   typedef enum int {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_PATTERN
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_position;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_length;
   logic        rsp_checksum_ok;
   logic [15:0] rsp_end_word;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_sync_word;

   // predictor state
   logic [15:0] sync_word_cfg;
   phase_type   dfr_phase;
   logic [7:0]  dfr_prev;
   logic        dfr_prev_valid;
   logic [8:0]  dfr_count;
   logic [7:0]  dfr_sum;
   logic [7:0]  dfr_command;
   logic [7:0]  dfr_length;
   logic [7:0]  dfr_sum_rx;
   logic [7:0]  dfr_end_low;

   result_type  deframed_due[$];
   result_type  want_beat;
   logic [7:0]  frame_buf[$];

   int fail_count     = 0;
   int bytes_sent     = 0;
   int burst_left     = 0;
   int holdoff_cycles = 0;
   int idle_cycles    = 0;
   bit sender_gaps    = 1'b1;

   at_reply_frame_deframer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_position    (rsp_position),
      .rsp_command     (rsp_command),
      .rsp_length      (rsp_length),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_end_word    (rsp_end_word),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_sync_word   (csr_sync_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void queue_beat(input result_type beat);
      deframed_due.insert(deframed_due.size(), beat);
   endfunction

   function automatic void frame_add(input logic [7:0] b);
      frame_buf.insert(frame_buf.size(), b);
   endfunction

   // advances the frame state by one received byte, queues the beat it causes
   function automatic void deframe_byte(input logic [7:0] b);
      result_type beat;
      beat = '0;
      beat.valid = 1'b1;
      case (dfr_phase)
         PH_HUNT: begin
            if (dfr_prev_valid && {b, dfr_prev} == sync_word_cfg) begin
               dfr_sum = dfr_prev + b;
               dfr_count = '0;
               dfr_phase = PH_HEADER;
            end else begin
               dfr_prev = b;
               dfr_prev_valid = 1'b1;
            end
         end
         PH_HEADER: begin
            dfr_sum = dfr_sum + b;
            dfr_count = dfr_count + 9'd1;
            if (dfr_count >= {1'b0, HEADER_BYTES}) begin
               dfr_count = '0;
               dfr_phase = PH_COMMAND;
            end
         end
         PH_COMMAND: begin
            dfr_sum = dfr_sum + b;
            dfr_command = b;
            dfr_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            dfr_sum = dfr_sum + b;
            dfr_length = b;
            dfr_count = '0;
            dfr_phase = (b == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            dfr_sum = dfr_sum + b;
            beat.kind = KIND_PAYLOAD;
            beat.data_byte = b;
            beat.position = dfr_count[7:0];
            beat.command = dfr_command;
            beat.length = dfr_length;
            queue_beat(beat);
            dfr_count = dfr_count + 9'd1;
            if (dfr_count >= {1'b0, dfr_length})
               dfr_phase = PH_CHECKSUM;
         end
         PH_CHECKSUM: begin
            dfr_sum_rx = b;
            dfr_phase = PH_END_LOW;
         end
         PH_END_LOW: begin
            dfr_end_low = b;
            dfr_phase = PH_END_HIGH;
         end
         default: begin
            beat.kind = KIND_VERDICT;
            beat.command = dfr_command;
            beat.length = dfr_length;
            beat.checksum_ok = (dfr_sum_rx == dfr_sum);
            beat.end_word = {b, dfr_end_low};
            beat.last = 1'b1;
            queue_beat(beat);
            dfr_phase = PH_HUNT;
            dfr_prev_valid = 1'b0;
            dfr_prev = '0;
            dfr_count = '0;
         end
      endcase
   endfunction

   // assembles one frame with the current sync word into frame_buf
   function automatic void build_frame(input logic [7:0] command, input int pay_len,
                                       input int fill, input logic [15:0] trailer,
                                       input bit corrupt);
      logic [7:0] check;
      frame_buf.delete();
      frame_add(sync_word_cfg[7:0]);
      frame_add(sync_word_cfg[15:8]);
      repeat (HEADER_BYTES) frame_add(8'($urandom_range(0, 255)));
      frame_add(command);
      frame_add(8'(pay_len));
      for (int i = 0; i < pay_len; i++)
         frame_add((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      check = '0;
      foreach (frame_buf[i]) check = check + frame_buf[i];
      if (corrupt)
         check = check ^ 8'($urandom_range(1, 255));
      frame_add(check);
      frame_add(trailer[7:0]);
      frame_add(trailer[15:8]);
   endfunction

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      deframe_byte(value);
      bytes_sent++;
   endtask

   task automatic send_frame_bytes(input int first, input int stop);
      for (int i = first; i < stop && i < frame_buf.size(); i++)
         send_byte(frame_buf[i]);
   endtask

   // stop sending and let every beat in flight come out
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (deframed_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic change_sync(input logic [15:0] value);
      settle_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_sync_word <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sync_word_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         fail_count++;
      end
   endtask

   // noise, an empty frame, then a one byte frame with a bad checksum
   task automatic test_frame_basics();
      send_byte(8'h00);
      send_byte(8'h12);
      build_frame(8'h00, 0, -1, 16'h0000, 1'b0);
      send_frame_bytes(0, frame_buf.size());
      // end code high byte equals the sync high byte: next sync needs two fresh bytes
      build_frame(8'hFF, 1, 8'hFF, {SYNC_RESET[15:8], 8'h00}, 1'b1);
      send_frame_bytes(0, frame_buf.size());
   endtask

   task automatic test_sync_word();
      logic [15:0] patterns[4];
      patterns = '{16'h0000, 16'hFFFF, 16'h00FF, 16'($urandom_range(0, 65535))};
      foreach (patterns[k]) begin
         change_sync(patterns[k]);
         repeat (2) begin
            build_frame(8'($urandom_range(0, 255)), $urandom_range(0, 4), -1,
                        16'($urandom_range(0, 65535)), 1'b0);
            send_frame_bytes(0, frame_buf.size());
         end
      end
      // new sync written while a frame is half way: that frame is not affected
      build_frame(8'h3C, 3, -1, 16'h1234, 1'b0);
      send_frame_bytes(0, 6);
      change_sync(16'($urandom_range(0, 65535)));
      send_frame_bytes(6, frame_buf.size());
      build_frame(8'hC3, 2, -1, 16'h4321, 1'b0);
      send_frame_bytes(0, frame_buf.size());
      change_sync(SYNC_RESET);
   endtask

   task automatic test_long_payload();
      build_frame(8'hA5, 255, -1, 16'hFFFF, 1'b0);
      send_frame_bytes(0, frame_buf.size());
      build_frame(8'h5A, 254, 8'h00, 16'($urandom_range(0, 65535)), 1'b1);
      send_frame_bytes(0, frame_buf.size());
   endtask

   // receiver holds off for a long stretch while bytes keep coming
   task automatic test_stall_pressure();
      sender_gaps = 1'b0;
      holdoff_cycles = HOLDOFF_LEN;
      build_frame(8'h77, 60, -1, 16'($urandom_range(0, 65535)), 1'b0);
      send_frame_bytes(0, frame_buf.size());
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      int choice;
      int pay_len;
      int next_resync;
      next_resync = bytes_sent + RESYNC_EVERY;
      while (bytes_sent < TARGET_BYTES) begin
         if (bytes_sent >= next_resync) begin
            case ($urandom_range(0, 3))
               0: change_sync(16'h0000);
               1: change_sync(16'hFFFF);
               default: change_sync(16'($urandom_range(0, 65535)));
            endcase
            next_resync = bytes_sent + RESYNC_EVERY;
         end
         if ($urandom_range(0, 15) == 0)
            sender_gaps = !sender_gaps;
         choice = $urandom_range(0, 99);
         pay_len = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 255)
                                                : $urandom_range(0, 16);
         build_frame(8'($urandom_range(0, 255)), pay_len, -1,
                     16'($urandom_range(0, 65535)), $urandom_range(0, 6) == 0);
         if (choice < 75)
            send_frame_bytes(0, frame_buf.size());
         else if (choice < 88)
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         else
            send_frame_bytes(0, $urandom_range(1, frame_buf.size() - 1));
      end
      sender_gaps = 1'b1;
   endtask

   initial begin : receiver
      stall_mode_type mode;
      int stretch;
      int held;
      int tick;
      rsp_stall = 1'b0;
      tick = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(20, 150);
         repeat (stretch) begin
            @(negedge clock);
            tick++;
            if (holdoff_cycles > 0) begin
               held = holdoff_cycles;
               holdoff_cycles = 0;
               rsp_stall <= 1'b1;
               repeat (held - 1) @(negedge clock);
            end else begin
               case (mode)
                  RX_OPEN:  rsp_stall <= 1'b0;
                  RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:  rsp_stall <= (tick % 5 < 2);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (deframed_due.size() == 0) begin
            $error("result beat with nothing expected: kind %0h", rsp_kind);
            fail_count++;
         end else begin
            want_beat = deframed_due.pop_front();
            compare_field("kind", want_beat.kind, rsp_kind);
            compare_field("data_byte", want_beat.data_byte, rsp_data_byte);
            compare_field("position", want_beat.position, rsp_position);
            compare_field("command", want_beat.command, rsp_command);
            compare_field("length", want_beat.length, rsp_length);
            compare_field("checksum_ok", want_beat.checksum_ok, rsp_checksum_ok);
            compare_field("end_word", want_beat.end_word, rsp_end_word);
            compare_field("last", want_beat.last, rsp_last);
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = '0;
      csr_valid = 1'b0;
      csr_sync_word = '0;
      sync_word_cfg = SYNC_RESET;
      dfr_phase = PH_HUNT;
      dfr_prev = '0;
      dfr_prev_valid = 1'b0;
      dfr_count = '0;
      dfr_sum = '0;
      dfr_command = '0;
      dfr_length = '0;
      dfr_sum_rx = '0;
      dfr_end_low = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_frame_basics();
      test_sync_word();
      test_long_payload();
      test_stall_pressure();
      test_random_traffic();

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
